@@ rtl/tsa_pkg.sv @@
// shared types and constants of the tag slot allocator
package tsa_pkg;

  localparam int DOMAIN_W   = 16;
  localparam int OLD_IDX_W  = 16;
  localparam int NEW_IDX_W  = 10;
  localparam int HWATER_W   = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // bitmap word geometry
  localparam int WORD_W = 16;
  localparam int WBIT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_DOMAIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESERVE  = 8'd1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DONE
  } state_t;

  // position of the lowest set bit
  function automatic logic [WBIT_W-1:0] first_set(input word_t w);
    logic [WBIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = WBIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ rtl/tsa_in_if.sv @@
// request channel carrying the old tag of an arriving item
interface tsa_in_if;
  logic                           valid;
  logic                           ready;
  logic [tsa_pkg::DOMAIN_W-1:0]   old_domain;
  logic [tsa_pkg::OLD_IDX_W-1:0]  old_index;

  modport source (output valid, old_domain, old_index, input ready);
  modport sink   (input valid, old_domain, old_index, output ready);
endinterface

@@ rtl/tsa_out_if.sv @@
// result channel carrying the assigned slot
interface tsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [tsa_pkg::NEW_IDX_W-1:0] new_index;
  logic                          remapped;
  logic                          full_res;
  logic [tsa_pkg::HWATER_W-1:0]  high_water;

  modport source (output valid, new_index, remapped, full_res, high_water, input ready);
  modport sink   (input valid, new_index, remapped, full_res, high_water, output ready);
endinterface

@@ rtl/tsa_cfg_if.sv @@
// configuration write channel
interface tsa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tsa_pkg::CFG_IDX_W-1:0]   index;
  logic [tsa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tag_slot_allocator.sv @@
// next-fit tag slot allocator over a word-wide occupancy bitmap in block ram
//
//   channel  | direction | contents
//   ---------+-----------+-------------------------------------------
//   in_ch    | sink      | old_domain, old_index
//   out_ch   | source    | new_index, remapped, full_res, high_water
//   cfg_ch   | sink      | index (0 my_domain, 1 preserve_tags), data
//
// a kept index reads only its own 16-slot bitmap word; a scan reads words from the one
// at the scan pointer onward, and a local old slot found taken falls back to the scan; a full
// table seen at the scan pointer answers without a bitmap read.
// after reset a clearing pass zeroes all ceil(TAG_SLOTS/16) bitmap words, one per cycle,
// with in_ch not ready; cfg writes are always taken.
// a new request is taken while the previous result waits in the output register.
module tag_slot_allocator #(
  parameter int TAG_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  tsa_in_if.sink      in_ch,
  tsa_out_if.source   out_ch,
  tsa_cfg_if.sink     cfg_ch
);

  localparam int WORD_W  = tsa_pkg::WORD_W;
  localparam int WBIT_W  = tsa_pkg::WBIT_W;
  localparam int NWORDS  = (TAG_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PTR_W   = $clog2(TAG_SLOTS + 1);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NWORDS - 1);
  localparam logic [PTR_W-1:0]   PTR_END   = PTR_W'(TAG_SLOTS);
  localparam tsa_pkg::word_t TAIL_MASK = ((TAG_SLOTS % WORD_W) == 0) ? '1 :
                                         WORD_W'((1 << (TAG_SLOTS % WORD_W)) - 1);

  tsa_pkg::state_t state_r, state_nxt;

  logic [WADDR_W-1:0] clr_r, clr_nxt;
  logic [WADDR_W-1:0] word_r, word_nxt;
  logic [WBIT_W-1:0]  kbit_r, kbit_nxt;
  logic               keep_r, keep_nxt;
  logic [PTR_W-1:0]   scan_ptr_r, scan_ptr_nxt;
  logic [PTR_W-1:0]   high_mark_r, high_mark_nxt;
  logic [tsa_pkg::DOMAIN_W-1:0] my_domain_r, my_domain_nxt;
  logic               preserve_r, preserve_nxt;

  logic [tsa_pkg::NEW_IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic               pend_remap_r, pend_remap_nxt;
  logic               pend_full_r, pend_full_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [tsa_pkg::NEW_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic               out_remap_r, out_remap_nxt;
  logic               out_full_r, out_full_nxt;
  logic [tsa_pkg::HWATER_W-1:0]  out_hw_r, out_hw_nxt;

  // bitmap memory
  tsa_pkg::word_t     mem [NWORDS];
  tsa_pkg::word_t     rd_data_r;
  logic [WADDR_W-1:0] rd_addr;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  tsa_pkg::word_t     wr_data;

  logic [31:0]        ptr_ext, idx_ext, chosen_ext, hm_ext;
  logic [WADDR_W-1:0] ptr_word, idx_word;
  logic               ptr_end, eligible, in_acc;
  tsa_pkg::word_t     free_w;
  logic [WBIT_W-1:0]  free_bit;
  logic [PTR_W-1:0]   chosen, chosen_p1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign ptr_ext  = 32'(scan_ptr_r);
  assign idx_ext  = 32'(in_ch.old_index);
  assign hm_ext   = 32'(high_mark_r);
  assign ptr_word = ptr_ext[WADDR_W+WBIT_W-1:WBIT_W];
  assign idx_word = idx_ext[WADDR_W+WBIT_W-1:WBIT_W];
  assign ptr_end  = (scan_ptr_r == PTR_END);
  assign eligible = (in_ch.old_domain == my_domain_r) && preserve_r &&
                    ({1'b0, in_ch.old_index} < 17'(TAG_SLOTS));
  assign in_acc   = in_ch.valid && in_ch.ready;

  // slots below the scan pointer are always used, so only the table tail is masked
  assign free_w    = ~rd_data_r & ((word_r == LAST_WORD) ? TAIL_MASK : '1);
  assign free_bit  = tsa_pkg::first_set(free_w);
  assign chosen    = PTR_W'({word_r, keep_r ? kbit_r : free_bit});
  assign chosen_p1 = chosen + PTR_W'(1);
  assign chosen_ext = 32'(chosen);

  assign in_ch.ready       = (state_r == tsa_pkg::ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_index  = out_idx_r;
  assign out_ch.remapped   = out_remap_r;
  assign out_ch.full_res   = out_full_r;
  assign out_ch.high_water = out_hw_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    word_nxt       = word_r;
    kbit_nxt       = kbit_r;
    keep_nxt       = keep_r;
    scan_ptr_nxt   = scan_ptr_r;
    high_mark_nxt  = high_mark_r;
    my_domain_nxt  = my_domain_r;
    preserve_nxt   = preserve_r;
    pend_idx_nxt   = pend_idx_r;
    pend_remap_nxt = pend_remap_r;
    pend_full_nxt  = pend_full_r;
    out_valid_nxt  = out_valid_r;
    out_idx_nxt    = out_idx_r;
    out_remap_nxt  = out_remap_r;
    out_full_nxt   = out_full_r;
    out_hw_nxt     = out_hw_r;
    rd_addr        = word_r;
    wr_en          = 1'b0;
    wr_addr        = word_r;
    wr_data        = rd_data_r;

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tsa_pkg::CFG_MY_DOMAIN: my_domain_nxt = cfg_ch.data[tsa_pkg::DOMAIN_W-1:0];
        tsa_pkg::CFG_PRESERVE:  preserve_nxt  = cfg_ch.data[0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tsa_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + WADDR_W'(1);
        if (clr_r == LAST_WORD) begin
          state_nxt = tsa_pkg::ST_IDLE;
        end
      end
      tsa_pkg::ST_IDLE: begin
        if (in_acc) begin
          pend_idx_nxt   = '0;
          pend_remap_nxt = 1'b0;
          pend_full_nxt  = 1'b0;
          if (eligible) begin
            word_nxt  = idx_word;
            kbit_nxt  = idx_ext[WBIT_W-1:0];
            keep_nxt  = 1'b1;
            rd_addr   = idx_word;
            state_nxt = tsa_pkg::ST_LOOK;
          end else if (ptr_end) begin
            pend_full_nxt = 1'b1;
            state_nxt     = tsa_pkg::ST_DONE;
          end else begin
            word_nxt  = ptr_word;
            keep_nxt  = 1'b0;
            rd_addr   = ptr_word;
            state_nxt = tsa_pkg::ST_LOOK;
          end
        end
      end
      tsa_pkg::ST_LOOK: begin
        if (keep_r ? !rd_data_r[kbit_r] : (free_w != '0)) begin
          // claim the slot
          wr_en        = 1'b1;
          wr_addr      = word_r;
          wr_data      = rd_data_r | (tsa_pkg::word_t'(1) << (keep_r ? kbit_r : free_bit));
          pend_idx_nxt = chosen_ext[tsa_pkg::NEW_IDX_W-1:0];
          pend_remap_nxt = !keep_r;
          if (chosen_p1 > high_mark_r) begin
            high_mark_nxt = chosen_p1;
          end
          if (!keep_r) begin
            scan_ptr_nxt = chosen_p1;
          end
          state_nxt = tsa_pkg::ST_DONE;
        end else if (keep_r) begin
          // old slot taken, fall back to the scan
          if (ptr_end) begin
            pend_full_nxt = 1'b1;
            state_nxt     = tsa_pkg::ST_DONE;
          end else begin
            word_nxt = ptr_word;
            keep_nxt = 1'b0;
            rd_addr  = ptr_word;
          end
        end else if (word_r == LAST_WORD) begin
          pend_full_nxt = 1'b1;
          state_nxt     = tsa_pkg::ST_DONE;
        end else begin
          word_nxt = word_r + WADDR_W'(1);
          rd_addr  = word_r + WADDR_W'(1);
        end
      end
      tsa_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = pend_idx_r;
          out_remap_nxt = pend_remap_r;
          out_full_nxt  = pend_full_r;
          out_hw_nxt    = hm_ext[tsa_pkg::HWATER_W-1:0];
          state_nxt     = tsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsa_pkg::ST_CLEAR;
      clr_r       <= '0;
      scan_ptr_r  <= '0;
      high_mark_r <= '0;
      my_domain_r <= '0;
      preserve_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      high_mark_r <= high_mark_nxt;
      my_domain_r <= my_domain_nxt;
      preserve_r  <= preserve_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    kbit_r       <= kbit_nxt;
    keep_r       <= keep_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_remap_r <= pend_remap_nxt;
    pend_full_r  <= pend_full_nxt;
    out_idx_r    <= out_idx_nxt;
    out_remap_r  <= out_remap_nxt;
    out_full_r   <= out_full_nxt;
    out_hw_r     <= out_hw_nxt;
  end

endmodule

@@ rtl/tsa_checker.sv @@
// port-level checks on the tag slot allocator and their binding
module tsa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tsa_pkg::NEW_IDX_W-1:0] out_new_index,
  input logic                          out_remapped,
  input logic                          out_full_res,
  input logic [tsa_pkg::HWATER_W-1:0]  out_high_water
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_index) &&
      $stable(out_remapped) && $stable(out_full_res) && $stable(out_high_water))
    else $error("result changed while stalled");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> out_new_index == '0 && !out_remapped)
    else $error("full result carries an index or remap");

  // the assigned slot lies below the high-water mark
  a_hw_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_full_res |->
      out_high_water > {1'b0, out_new_index} || out_high_water[tsa_pkg::HWATER_W-1])
    else $error("high water below assigned slot");

  a_hw_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_full_res |-> out_high_water != '0)
    else $error("allocation with zero high water");

endmodule

bind tag_slot_allocator tsa_checker u_tsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_new_index  (out_ch.new_index),
  .out_remapped   (out_ch.remapped),
  .out_full_res   (out_ch.full_res),
  .out_high_water (out_ch.high_water)
);

@@ sim/testbench.sv @@
// self-checking testbench for the tag slot allocator
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS       = 1024;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_LEN    = 300;
  localparam int CALM_LO     = 400;
  localparam int CALM_HI     = 600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_MAX   = 40;

  localparam logic [tsa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
  localparam logic [tsa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

  typedef struct packed {
    logic [tsa_pkg::NEW_IDX_W-1:0] new_index;
    logic                          remapped;
    logic                          full_res;
    logic [tsa_pkg::HWATER_W-1:0]  high_water;
  } slot_result_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  // reg rows carry the register index and write data in the two 16-bit fields
  typedef struct packed {
    row_kind_t            kind;
    logic [15:0]          dom_or_reg;
    logic [15:0]          idx_or_data;
    logic                 typed;
    slot_result_t         want;
  } dir_row_t;

  localparam slot_result_t NONE = '0;

  localparam dir_row_t DIR_TAB [24] = '{
    '{ROW_ITEM, 16'h0000, 16'd0,    1'b1, '{10'd0,    1'b0, 1'b0, 11'd1}},
    '{ROW_ITEM, 16'h0000, 16'd1023, 1'b1, '{10'd1023, 1'b0, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'h0000, 16'd1023, 1'b1, '{10'd1,    1'b1, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'h0000, 16'd1024, 1'b1, '{10'd2,    1'b1, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'h0000, 16'hFFFF, 1'b1, '{10'd3,    1'b1, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'hFFFF, 16'd4,    1'b1, '{10'd4,    1'b1, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'h0000, 16'd6,    1'b1, '{10'd6,    1'b0, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'h8000, 16'd0,    1'b1, '{10'd5,    1'b1, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'h0001, 16'd0,    1'b1, '{10'd7,    1'b1, 1'b0, 11'd1024}},
    '{ROW_REG,  16'(tsa_pkg::CFG_MY_DOMAIN), 16'hFFFF, 1'b0, NONE},
    '{ROW_ITEM, 16'hFFFF, 16'h03FE, 1'b1, '{10'd1022, 1'b0, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'h0000, 16'd9,    1'b1, '{10'd8,    1'b1, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'hFFFF, 16'h0400, 1'b1, '{10'd9,    1'b1, 1'b0, 11'd1024}},
    '{ROW_REG,  16'(tsa_pkg::CFG_PRESERVE),  16'hFFFE, 1'b0, NONE},
    '{ROW_ITEM, 16'hFFFF, 16'd20,   1'b1, '{10'd10,   1'b1, 1'b0, 11'd1024}},
    '{ROW_REG,  16'(CFG_UNUSED_LO), 16'h0000, 1'b0, NONE},
    '{ROW_REG,  16'(CFG_UNUSED_HI), 16'h0001, 1'b0, NONE},
    '{ROW_ITEM, 16'hFFFF, 16'd30,   1'b1, '{10'd11,   1'b1, 1'b0, 11'd1024}},
    '{ROW_REG,  16'(tsa_pkg::CFG_PRESERVE),  16'h0001, 1'b0, NONE},
    '{ROW_REG,  16'(tsa_pkg::CFG_MY_DOMAIN), 16'h0000, 1'b0, NONE},
    '{ROW_ITEM, 16'h0000, 16'd12,   1'b1, '{10'd12,   1'b0, 1'b0, 11'd1024}},
    '{ROW_ITEM, 16'h7FFF, 16'd12,   1'b0, NONE},
    '{ROW_ITEM, 16'h0000, 16'h8155, 1'b0, NONE},
    '{ROW_ITEM, 16'h0000, 16'd15,   1'b1, '{10'd15,   1'b0, 1'b0, 11'd1024}}
  };

  localparam logic [15:0] PH_DOMAIN   [PHASES] = '{16'h0000, 16'hFFFF, 16'h1234,
                                                   16'h0000, 16'hFFFF, 16'h8001};
  localparam logic        PH_PRESERVE [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  logic clk = 1'b0;
  logic rst_n;

  tsa_in_if  in_ch ();
  tsa_out_if out_ch ();
  tsa_cfg_if cfg_ch ();

  tag_slot_allocator #(.TAG_SLOTS(SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // allocator state as the block should hold it
  bit [SLOTS-1:0]     slot_taken;
  int unsigned        scan_ptr;
  int unsigned        hw_mark;
  logic [15:0]        cur_domain;
  logic               cur_preserve;

  slot_result_t       pending_slots [$];
  int                 mismatches;
  int                 items_sent;
  int                 results_seen;
  int unsigned        cycle_count;

  function automatic void take_slot(input int unsigned slot);
    slot_taken[slot] = 1'b1;
    if (slot + 1 > hw_mark) begin
      hw_mark = slot + 1;
    end
  endfunction

  function automatic slot_result_t assign_slot(input logic [15:0] dom,
                                               input logic [15:0] idx);
    slot_result_t r;
    int unsigned  p;
    r = '0;
    if (dom == cur_domain && cur_preserve && idx < SLOTS && !slot_taken[idx]) begin
      r.new_index = idx[tsa_pkg::NEW_IDX_W-1:0];
      take_slot(idx);
    end else begin
      p = scan_ptr;
      while (p < SLOTS && slot_taken[p]) begin
        p++;
      end
      if (p < SLOTS) begin
        r.new_index = p[tsa_pkg::NEW_IDX_W-1:0];
        r.remapped  = 1'b1;
        take_slot(p);
        scan_ptr = p + 1;
      end else begin
        r.full_res = 1'b1;
      end
    end
    r.high_water = hw_mark[tsa_pkg::HWATER_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_MAX) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
    mismatches++;
  endtask

  task automatic offer_item(input logic [15:0] dom, input logic [15:0] idx,
                            input logic typed, input slot_result_t want);
    slot_result_t predicted;
    bool_gap: begin
      if (!(items_sent >= CALM_LO && items_sent < CALM_HI) &&
          $urandom_range(0, 99) < 15) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.old_domain <= dom;
    in_ch.old_index  <= idx;
    do @(posedge clk); while (!in_ch.ready);
    predicted = assign_slot(dom, idx);
    pending_slots.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // registers change only with no request in flight
  task automatic write_reg(input logic [tsa_pkg::CFG_IDX_W-1:0] ridx,
                           input logic [15:0] val);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_slots.size() != 0);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ridx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (ridx == tsa_pkg::CFG_MY_DOMAIN) begin
      cur_domain = val;
    end else if (ridx == tsa_pkg::CFG_PRESERVE) begin
      cur_preserve = val[0];
    end
  endtask

  task automatic check_result();
    slot_result_t want;
    if (pending_slots.size() == 0) begin
      flag_mismatch($sformatf("result new_index %0d with no request pending",
                              out_ch.new_index));
    end else begin
      want = pending_slots.pop_front();
      if (out_ch.new_index !== want.new_index) begin
        flag_mismatch($sformatf("new_index %0d, expected %0d",
                                out_ch.new_index, want.new_index));
      end
      if (out_ch.remapped !== want.remapped) begin
        flag_mismatch($sformatf("remapped %b, expected %b", out_ch.remapped, want.remapped));
      end
      if (out_ch.full_res !== want.full_res) begin
        flag_mismatch($sformatf("full_res %b, expected %b", out_ch.full_res, want.full_res));
      end
      if (out_ch.high_water !== want.high_water) begin
        flag_mismatch($sformatf("high_water %0d, expected %0d",
                                out_ch.high_water, want.high_water));
      end
    end
    results_seen++;
  endtask

  // result side: random stalls, one long hold so the block backs up
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_result();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (results_seen >= CALM_LO && results_seen < CALM_HI) ||
                        ($urandom_range(0, 99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    logic [15:0] dom;
    logic [15:0] idx;
    int          pick;
    slot_taken       = '0;
    scan_ptr         = 0;
    hw_mark          = 0;
    cur_domain       = '0;
    cur_preserve     = 1'b1;
    mismatches       = 0;
    items_sent       = 0;
    results_seen     = 0;
    cycle_count      = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.old_domain = '0;
    in_ch.old_index  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_REG) begin
        write_reg(DIR_TAB[i].dom_or_reg[tsa_pkg::CFG_IDX_W-1:0], DIR_TAB[i].idx_or_data);
      end else begin
        offer_item(DIR_TAB[i].dom_or_reg, DIR_TAB[i].idx_or_data,
                   DIR_TAB[i].typed, DIR_TAB[i].want);
      end
    end

    // each phase drains the block, then sets both registers
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(tsa_pkg::CFG_MY_DOMAIN, (ph == 3) ? 16'($urandom) : PH_DOMAIN[ph]);
      write_reg(tsa_pkg::CFG_PRESERVE, {15'($urandom), PH_PRESERVE[ph]});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          dom = cur_domain;
          idx = 16'($urandom_range(0, SLOTS - 1));
        end else if (pick < 50) begin
          // keep a slot just ahead of the scan so later scans skip over it
          dom = cur_domain;
          idx = 16'(scan_ptr + $urandom_range(0, 40));
        end else if (pick < 60) begin
          dom = cur_domain;
          idx = 16'($urandom);
        end else if (pick < 70) begin
          dom = cur_domain ^ (16'd1 << $urandom_range(0, 15));
          idx = 16'($urandom_range(0, SLOTS - 1));
        end else begin
          dom = 16'($urandom);
          idx = 16'($urandom);
        end
        offer_item(dom, idx, 1'b0, NONE);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tsa_pkg.sv
rtl/tsa_in_if.sv
rtl/tsa_out_if.sv
rtl/tsa_cfg_if.sv
rtl/tag_slot_allocator.sv
rtl/tsa_checker.sv
sim/testbench.sv
